// File: src/nearest_integer_power_defines.svh
// Assertion macros for the nearest integer power block.
// Included by the top level; it depends on nothing else.
`ifndef NEAREST_INTEGER_POWER_DEFINES_SVH
`define NEAREST_INTEGER_POWER_DEFINES_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define NIP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest_integer_power: same-cycle check failed");
// Implication into the next cycle.
`define NIP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest_integer_power: next-cycle check failed");
`else
`define NIP_ASSERT_IMP(label, clk, rst, ante, cons)
`define NIP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/nip_pkg.sv
// Shared types, constants and the microcode ROM of the nearest integer power block.
// Used by the sequencer and the top level; depends on nothing.
`timescale 1ns / 1ps
package nip_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int IN_W  = 16;
  localparam int EXP_W = 5;
  localparam int OUT_W = 32;

  // Largest exponent used; higher requests are clamped to it.
  localparam logic [EXP_W-1:0] MAX_EXPONENT = 5'd31;
  localparam logic [EXP_W-1:0] EXP_ZERO     = 5'd0;
  localparam logic [EXP_W-1:0] EXP_ONE      = 5'd1;

  // Microcode step addresses.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CHECK = 3'd1,
    ST_TRY   = 3'd2,
    ST_MUL   = 3'd3,
    ST_CMP   = 3'd4,
    ST_UP    = 3'd5,
    ST_MULU  = 3'd6,
    ST_FIN   = 3'd7
  } step_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    JC_ALWAYS   = 3'd0,
    JC_START    = 3'd1,
    JC_SPECIAL  = 3'd2,
    JC_CNT_LAST = 3'd3,
    JC_BIT_LAST = 3'd4
  } jcond_t;

  // One control word: datapath strobes, then the jump condition and both targets.
  typedef struct packed {
    logic   init;
    logic   try_ld;
    logic   up_ld;
    logic   mul;
    logic   cmp;
    logic   fin;
    jcond_t cond;
    step_t  tgt_t;
    step_t  tgt_f;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic start_ok;
    logic special;
    logic cnt_last;
    logic bit_last;
  } flags_t;

  // The program. The root is built one bit at a time from the top; each trial base
  // is raised to the exponent on the shared multiplier, then the base above the
  // root is raised to give the upper power.
  function automatic uword_t ucode(step_t step);
    uword_t w;
    w = '0;
    w.cond  = JC_ALWAYS;
    w.tgt_t = ST_IDLE;
    w.tgt_f = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        w.cond  = JC_START;
        w.tgt_t = ST_CHECK;
        w.tgt_f = ST_IDLE;
      end
      ST_CHECK: begin
        w.init  = 1'b1;
        w.cond  = JC_SPECIAL;
        w.tgt_t = ST_FIN;
        w.tgt_f = ST_TRY;
      end
      ST_TRY: begin
        w.try_ld = 1'b1;
        w.tgt_t  = ST_MUL;
        w.tgt_f  = ST_MUL;
      end
      ST_MUL: begin
        w.mul   = 1'b1;
        w.cond  = JC_CNT_LAST;
        w.tgt_t = ST_CMP;
        w.tgt_f = ST_MUL;
      end
      ST_CMP: begin
        w.cmp   = 1'b1;
        w.cond  = JC_BIT_LAST;
        w.tgt_t = ST_UP;
        w.tgt_f = ST_TRY;
      end
      ST_UP: begin
        w.up_ld = 1'b1;
        w.tgt_t = ST_MULU;
        w.tgt_f = ST_MULU;
      end
      ST_MULU: begin
        w.mul   = 1'b1;
        w.cond  = JC_CNT_LAST;
        w.tgt_t = ST_FIN;
        w.tgt_f = ST_MULU;
      end
      ST_FIN: begin
        w.fin   = 1'b1;
        w.tgt_t = ST_IDLE;
        w.tgt_f = ST_IDLE;
      end
      default: begin
        w.tgt_t = ST_IDLE;
        w.tgt_f = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/nip_seq.sv
// Microcode sequencer of the nearest integer power block: step counter,
// control ROM and conditional jumps. Depends on nip_pkg.
`timescale 1ns / 1ps
module nip_seq (
  input  logic            clk,
  input  logic            rst,
  input  nip_pkg::flags_t flags,
  output nip_pkg::uword_t uword,
  output logic            busy
);
  import nip_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  take;

  // Control word of the current step.
  assign uword = ucode(pc);

  // Choose the next step from the jump condition.
  always_comb begin
    unique case (uword.cond)
      JC_ALWAYS:   take = 1'b1;
      JC_START:    take = flags.start_ok;
      JC_SPECIAL:  take = flags.special;
      JC_CNT_LAST: take = flags.cnt_last;
      JC_BIT_LAST: take = flags.bit_last;
      default:     take = 1'b1;
    endcase
    pc_next = take ? uword.tgt_t : uword.tgt_f;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != ST_IDLE);

endmodule

// File: src/nearest_integer_power.sv
// Top level of the nearest integer power block: datapath with one shared multiplier.
// Depends on nip_pkg, nip_seq and nearest_integer_power_defines.svh.
`timescale 1ns / 1ps
`include "nearest_integer_power_defines.svh"
// Usage:
// An item (value, exponent) is taken at a rising edge where start is high and busy
// is low. The block answers each item with one result on nearest_power, marked by
// done for exactly one cycle; the receiver must take it then, as it cannot stall.
// busy is low again in the cycle where done is high, so the next item may be
// started while the result is on the ports.
// With p the clamped exponent and R = (VALUE_WIDTH+1)/2 root bits: for p of 0 or 1
// the result is chosen directly after the check; for p of 2 up, the work is done on
// the single multiplier: each of the R trial root bits raises a base to the exponent
// with one multiplication a cycle, and the upper power needs p more multiplications.
// One item is worked on at a time; the next one can be taken at the earliest at the
// edge that ends the done cycle.
// Synchronous reset returns the sequencer to idle and clears done; any item in
// progress is dropped.
module nearest_integer_power #(
  parameter int VALUE_WIDTH = nip_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nip_pkg::IN_W-1:0]   value,
  input  logic [nip_pkg::EXP_W-1:0]  exponent,
  output logic                       busy,
  output logic                       done,
  output logic [nip_pkg::OUT_W-1:0]  nearest_power
);
  import nip_pkg::*;

  localparam int RB    = (VALUE_WIDTH + 1) / 2;
  localparam int BW    = RB + 1;
  localparam int AW    = VALUE_WIDTH + 2;
  localparam int PW    = AW + BW;
  localparam int BIT_W = $clog2(RB);
  localparam int EXT_W = VALUE_WIDTH + IN_W;
  localparam int RES_W = AW + OUT_W;

  // Saturation level for powers: above twice any value, so the order is kept.
  localparam logic [AW-1:0]    CAP      = {1'b1, {(VALUE_WIDTH + 1){1'b0}}};
  localparam logic [AW-1:0]    ACC_ONE  = {{(AW - 1){1'b0}}, 1'b1};
  localparam logic [BW-1:0]    BASE_ONE = {{(BW - 1){1'b0}}, 1'b1};
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(RB - 1);

  uword_t uword;
  flags_t flags;

  logic [VALUE_WIDTH-1:0] v;
  logic [EXP_W-1:0]       p;
  logic [BW-1:0]          lo;
  logic [BW-1:0]          trial;
  logic [AW-1:0]          acc;
  logic [AW-1:0]          low_pow;
  logic [EXP_W-1:0]       cnt;
  logic [BIT_W-1:0]       bit_idx;

  logic [EXT_W-1:0]       value_ext;
  logic [VALUE_WIDTH-1:0] v_in;
  logic [EXP_W-1:0]       p_in;
  logic [AW-1:0]          v_a;
  logic [PW-1:0]          prod;
  logic [AW-1:0]          acc_mul;
  logic [AW-1:0]          diff_lo;
  logic [AW-1:0]          diff_up;
  logic [AW-1:0]          res;
  logic [RES_W-1:0]       res_ext;

  nip_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uword (uword),
    .busy  (busy)
  );

  // Input conditioning: keep the low value bits and clamp the exponent.
  assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
  assign v_in      = value_ext[VALUE_WIDTH-1:0];
  assign p_in      = (exponent > MAX_EXPONENT) ? MAX_EXPONENT : exponent;
  assign v_a       = {2'b00, v};

  // Status for the sequencer.
  assign flags.start_ok = start && !busy;
  assign flags.special  = (p == EXP_ZERO) || (p == EXP_ONE);
  assign flags.cnt_last = (cnt == EXP_ONE);
  assign flags.bit_last = (bit_idx == '0);

  // Shared multiplier with saturation at the cap.
  assign prod    = {{BW{1'b0}}, acc} * {{AW{1'b0}}, trial};
  assign acc_mul = (prod > {{BW{1'b0}}, CAP}) ? CAP : prod[AW-1:0];

  // Final choice: for p of 2 up, lower power unless the upper one is strictly nearer.
  always_comb begin
    diff_lo = v_a - low_pow;
    diff_up = acc - v_a;
    if (p == EXP_ZERO) begin
      res = (v != '0) ? ACC_ONE : '0;
    end else if (p == EXP_ONE) begin
      res = v_a;
    end else if (diff_lo <= diff_up) begin
      res = low_pow;
    end else begin
      res = acc;
    end
    res_ext = {{OUT_W{1'b0}}, res};
  end

  // Datapath registers: the operands are loaded on acceptance, the rest under their control word bits.
  always_ff @(posedge clk) begin
    if (flags.start_ok) begin
      v <= v_in;
      p <= p_in;
    end
    if (uword.init) begin
      lo      <= '0;
      low_pow <= '0;
      bit_idx <= LAST_BIT;
    end
    if (uword.try_ld) begin
      trial <= lo | (BASE_ONE << bit_idx);
      acc   <= ACC_ONE;
      cnt   <= p;
    end
    if (uword.up_ld) begin
      trial <= lo + BASE_ONE;
      acc   <= ACC_ONE;
      cnt   <= p;
    end
    if (uword.mul) begin
      acc <= acc_mul;
      cnt <= cnt - EXP_ONE;
    end
    if (uword.cmp) begin
      if (acc <= v_a) begin
        lo      <= trial;
        low_pow <= acc;
      end
      bit_idx <= bit_idx - BIT_W'(1);
    end
    if (uword.fin) begin
      nearest_power <= res_ext[OUT_W-1:0];
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= uword.fin;
    end
  end

  // Checks on the sequencing and the datapath.
  `NIP_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `NIP_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `NIP_ASSERT_IMP(a_acc_cap, clk, rst, uword.mul || uword.cmp, acc <= CAP)
  `NIP_ASSERT_NXT(a_low_below, clk, rst, uword.cmp, low_pow <= v_a)

endmodule
